// ===== rtl/header_delimited_frame_splitter_top_macros.svh =====
// ----------------------------------------------------------------------------
// header delimited frame splitter assertion macros
// concurrent assertion shorthands used by the checker file hdfs_checker.sv
// ----------------------------------------------------------------------------
`ifndef HEADER_DELIMITED_FRAME_SPLITTER_TOP_MACROS_SVH
`define HEADER_DELIMITED_FRAME_SPLITTER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HDFS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define HDFS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// hdfs_pkg
// constants, types and header match function of the frame splitter
// ----------------------------------------------------------------------------
`default_nettype none

package hdfs_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int MAX_HEADERS = 4;
    localparam int HEADER_REGS = 4;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int HCNT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_0     = 3'd0,
        CFG_HEADER_1     = 3'd1,
        CFG_HEADER_2     = 3'd2,
        CFG_HEADER_3     = 3'd3,
        CFG_HEADER_COUNT = 3'd4,
        CFG_IDLE_LIMIT   = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        CAUSE_HEADER = 1'b0,
        CAUSE_IDLE   = 1'b1
    } t_cause;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_WR0,
        S_WR1
    } t_state;

    typedef logic [WORD_W-1:0] t_hdr_words [HEADER_REGS];

    function automatic logic word_match(
        input t_hdr_words           words,
        input logic [HCNT_W-1:0]    count,
        input logic [WORD_W-1:0]    word
    );
        logic [HCNT_W-1:0] used;
        logic              hit;
        used = (count > HCNT_W'(MAX_HEADERS)) ? HCNT_W'(MAX_HEADERS) : count;
        hit  = 1'b0;
        for (int i = 0; i < HEADER_REGS; i++) begin
            if ((HCNT_W'(i) < used) && (words[i] == word)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hdfs_ram.sv =====
// ----------------------------------------------------------------------------
// hdfs_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/header_delimited_frame_splitter_top.sv =====
// ----------------------------------------------------------------------------
// header_delimited_frame_splitter_top
// splits a serial byte stream into frames that start with a two-byte header
// ----------------------------------------------------------------------------
// An input transfer is a received byte (tuser 0) or one idle tick (tuser 1).
// A byte or tick that ends no frame is handled in the cycle it is taken and
// the block is ready again on the next cycle. When a frame is emitted the
// block stops taking input while it drains the frame buffer: for each byte
// it issues a read (S_READ), then the registered read data loads the output
// register (S_LOAD) once that register is free, and a frame ended by a new
// header then writes the new header pair into the buffer through its single
// write port (S_WR0, S_WR1). Configuration writes are taken at any time but
// are meant for when the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module header_delimited_frame_splitter_top
    import hdfs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    input  wire logic                  s_axis_tuser,   // [0] operation
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
    output logic                       m_axis_tlast,
    output logic [1:0]                 m_axis_tuser    // [0] overflowed, [1] cause
);

    // configuration
    t_hdr_words               r_hdr_word;
    logic [HCNT_W-1:0]        r_hdr_count;
    logic [WORD_W-1:0]        r_idle_limit;

    // frame state
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_bcount, n_bcount;
    logic [WORD_W-1:0]        r_ticks, n_ticks;
    logic                     r_ovf, n_ovf;
    logic [BYTE_W-1:0]        r_hdr0, n_hdr0;
    logic [BYTE_W-1:0]        r_hdr1, n_hdr1;
    logic [BYTE_W-1:0]        r_last, n_last;

    // drain control
    logic [CNT_W-1:0]         r_len, n_len;
    logic [ADDR_W-1:0]        r_idx, n_idx;
    logic                     r_cause, n_cause;
    logic                     r_emit_ovf, n_emit_ovf;
    logic [BYTE_W-1:0]        r_pend1, n_pend1;

    // output register
    logic                     r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]        r_out_byte, n_out_byte;
    logic [ADDR_W-1:0]        r_out_idx, n_out_idx;
    logic                     r_out_last, n_out_last;
    logic                     r_out_ovf, n_out_ovf;
    logic                     r_out_cause, n_out_cause;

    // ram port
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [BYTE_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [BYTE_W-1:0]        ram_rdata;

    logic                     in_xfer;
    logic                     out_free;
    logic [BYTE_W-1:0]        rx_byte;
    logic [WORD_W-1:0]        ticks_inc;
    logic                     is_last;

    hdfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign rx_byte       = s_axis_tdata;
    assign ticks_inc     = (r_ticks == '1) ? r_ticks : r_ticks + WORD_W'(1);
    assign is_last       = ({1'b0, r_idx} + CNT_W'(1)) == r_len;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HEADER_REGS; i++) begin
                r_hdr_word[i] <= '0;
            end
            r_hdr_count  <= HCNT_W'(1);
            r_idle_limit <= WORD_W'(10);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEADER_0:     r_hdr_word[0] <= i_cfg_data;
                CFG_HEADER_1:     r_hdr_word[1] <= i_cfg_data;
                CFG_HEADER_2:     r_hdr_word[2] <= i_cfg_data;
                CFG_HEADER_3:     r_hdr_word[3] <= i_cfg_data;
                CFG_HEADER_COUNT: r_hdr_count   <= i_cfg_data[HCNT_W-1:0];
                CFG_IDLE_LIMIT:   r_idle_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bcount    <= '0;
            r_ticks     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bcount    <= n_bcount;
            r_ticks     <= n_ticks;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hdr0      <= n_hdr0;
        r_hdr1      <= n_hdr1;
        r_last      <= n_last;
        r_len       <= n_len;
        r_idx       <= n_idx;
        r_cause     <= n_cause;
        r_emit_ovf  <= n_emit_ovf;
        r_pend1     <= n_pend1;
        r_out_byte  <= n_out_byte;
        r_out_idx   <= n_out_idx;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
        r_out_cause <= n_out_cause;
    end

    always_comb begin
        n_state     = r_state;
        n_bcount    = r_bcount;
        n_ticks     = r_ticks;
        n_ovf       = r_ovf;
        n_hdr0      = r_hdr0;
        n_hdr1      = r_hdr1;
        n_last      = r_last;
        n_len       = r_len;
        n_idx       = r_idx;
        n_cause     = r_cause;
        n_emit_ovf  = r_emit_ovf;
        n_pend1     = r_pend1;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_byte  = r_out_byte;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_out_cause = r_out_cause;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = rx_byte;
        ram_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (t_op'(s_axis_tuser) == OP_TICK)) begin
                    n_ticks = ticks_inc;
                    if ((ticks_inc > r_idle_limit) && (r_bcount > CNT_W'(2)) &&
                        word_match(r_hdr_word, r_hdr_count, {r_hdr0, r_hdr1})) begin
                        n_len      = r_bcount;
                        n_idx      = '0;
                        n_cause    = CAUSE_IDLE;
                        n_emit_ovf = r_ovf;
                        n_ovf      = 1'b0;
                        n_bcount   = '0;
                        n_ticks    = '0;
                        n_state    = S_READ;
                    end
                end else if (in_xfer) begin
                    n_ticks = '0;
                    if (r_bcount == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        n_hdr0    = rx_byte;
                        n_last    = rx_byte;
                        n_bcount  = CNT_W'(1);
                    end else if (r_bcount == CNT_W'(1)) begin
                        ram_we = 1'b1;
                        n_last = rx_byte;
                        if (word_match(r_hdr_word, r_hdr_count, {r_hdr0, rx_byte})) begin
                            ram_waddr = ADDR_W'(1);
                            n_hdr1    = rx_byte;
                            n_bcount  = CNT_W'(2);
                        end else begin
                            // no header: frame start slides on to this byte
                            ram_waddr = '0;
                            n_hdr0    = rx_byte;
                        end
                    end else if (word_match(r_hdr_word, r_hdr_count, {r_last, rx_byte}) &&
                                 word_match(r_hdr_word, r_hdr_count, {r_hdr0, r_hdr1})) begin
                        // new header: emit all but the stored first byte of the new header
                        n_len      = r_bcount - CNT_W'(1);
                        n_idx      = '0;
                        n_cause    = CAUSE_HEADER;
                        n_emit_ovf = r_ovf;
                        n_ovf      = 1'b0;
                        n_pend1    = rx_byte;
                        n_hdr0     = r_last;
                        n_hdr1     = rx_byte;
                        n_last     = rx_byte;
                        n_bcount   = CNT_W'(2);
                        n_state    = S_READ;
                    end else if (r_bcount < CNT_W'(FRAME_BYTES)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_bcount[ADDR_W-1:0];
                        n_last    = rx_byte;
                        n_bcount  = r_bcount + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = ram_rdata;
                    n_out_idx   = r_idx;
                    n_out_last  = is_last;
                    n_out_ovf   = r_emit_ovf;
                    n_out_cause = r_cause;
                    if (!is_last) begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = S_READ;
                    end else if (t_cause'(r_cause) == CAUSE_HEADER) begin
                        n_state = S_WR0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WR0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_hdr0;
                n_state   = S_WR1;
            end
            S_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(1);
                ram_wdata = r_pend1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_idx, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_cause, r_out_ovf};

endmodule

`default_nettype wire

// ===== rtl/hdfs_checker.sv =====
// ----------------------------------------------------------------------------
// hdfs_checker
// port-level checks for the header delimited frame splitter
// ----------------------------------------------------------------------------
`default_nettype none

`include "header_delimited_frame_splitter_top_macros.svh"

module hdfs_checker
    import hdfs_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [15:0]           m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_index
    input wire logic                  m_axis_tlast,
    input wire logic [1:0]            m_axis_tuser    // [0] overflowed, [1] cause
);

    logic              out_xfer;
    logic              out_stall;
    logic              mid_frame;
    logic [19:0]       out_bus;
    logic [ADDR_W-1:0] out_idx;
    logic [1:0]        out_pad;
    logic [ADDR_W-1:0] r_exp_idx;

    assign out_xfer  = m_axis_tvalid && m_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign mid_frame = m_axis_tvalid && !m_axis_tlast;
    assign out_bus   = {m_axis_tvalid, m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign out_idx   = m_axis_tdata[13:8];
    assign out_pad   = m_axis_tdata[15:14];

    // index the next output transfer should carry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (out_xfer) begin
            r_exp_idx <= m_axis_tlast ? '0 : out_idx + ADDR_W'(1);
        end
    end

    `HDFS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, $stable(out_bus), "held output changed")
    `HDFS_ASSERT_IMP(a_idx_seq, i_clk, i_rst_n, out_xfer, out_idx == r_exp_idx, "index out of order")
    `HDFS_ASSERT_IMP(a_no_input_mid_frame, i_clk, i_rst_n, mid_frame, !s_axis_tready, "ready mid frame")
    `HDFS_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, out_pad == 2'b00, "nonzero padding")

endmodule

bind header_delimited_frame_splitter_top hdfs_checker u_hdfs_checker (.*);

`default_nettype wire
